>>> hdl/fsp_pkg.sv
// shared types and constants of the frame signal pack/unpack block
`default_nettype none
package fsp_pkg;

  localparam int WIN_BITS   = 32;
  localparam int NUM_LANES  = 4;
  localparam int ROW_CALC_W = 16;

  typedef enum logic [1:0] {
    CMD_WRITE_BYTE = 2'd0,
    CMD_READ_BYTE  = 2'd1,
    CMD_INSERT     = 2'd2,
    CMD_EXTRACT    = 2'd3
  } cmd_e;

  // decoded request as it travels from the address stage to the merge stage
  typedef struct packed {
    cmd_e                  cmd;
    logic                  err;
    logic [NUM_LANES-1:0]  lane_en;
    logic [1:0]            base_lo;
    logic [2:0]            bit_off;
    logic [5:0]            bit_len;
    logic                  moto;
    logic                  sgn;
    logic [7:0]            byte_val;
    logic [WIN_BITS-1:0]   sig_val;
  } req_t;

endpackage
`default_nettype wire

>>> hdl/fsp_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire  [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                 wdata_i,
  input  wire                              re_i,
  input  wire  [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/fsp_decode.sv
// request decode: parameter checks and per-bank row addresses of the byte window
`default_nettype none
module fsp_decode #(
  parameter int BUFFER_BITS     = 512,
  parameter int MAX_SIGNAL_BITS = 32,
  parameter int ROW_W           = 4
) (
  input  wire  [1:0]           command_i,
  input  wire  [5:0]           byte_index_i,
  input  wire  [7:0]           byte_value_i,
  input  wire  [8:0]           start_bit_i,
  input  wire  [5:0]           bit_length_i,
  input  wire                  motorola_order_i,
  input  wire                  signed_signal_i,
  input  wire  [31:0]          signal_value_i,
  output fsp_pkg::req_t        req_o,
  output logic [ROW_W-1:0]     row_o [fsp_pkg::NUM_LANES]
);

  localparam int BUF_BYTES = BUFFER_BITS / 8;

  fsp_pkg::cmd_e cmd;
  logic          is_raw;
  logic          idx_ok;
  logic          sig_ok;
  logic [31:0]   start_w;
  logic [31:0]   len_w;
  logic [31:0]   off_len_w;
  logic [5:0]    base;
  logic [4:0]    row_base;
  logic [4:0]    row_sig [fsp_pkg::NUM_LANES];
  logic [6:0]    byte_addr [fsp_pkg::NUM_LANES];
  logic [fsp_pkg::ROW_CALC_W-1:0] row_wide [fsp_pkg::NUM_LANES];

  always_comb begin
    cmd       = fsp_pkg::cmd_e'(command_i);
    is_raw    = (cmd == fsp_pkg::CMD_WRITE_BYTE) || (cmd == fsp_pkg::CMD_READ_BYTE);
    start_w   = 32'(start_bit_i);
    len_w     = 32'(bit_length_i);
    off_len_w = 32'(start_bit_i[2:0]) + len_w;
    idx_ok    = 32'(byte_index_i) < 32'(BUF_BYTES);
    sig_ok    = (start_w <= 32'(BUFFER_BITS - 1))
             && (start_w + len_w <= 32'(BUFFER_BITS))
             && (len_w != 32'd0)
             && (len_w <= 32'(MAX_SIGNAL_BITS))
             && (len_w <= 32'(fsp_pkg::WIN_BITS))
             && (off_len_w <= 32'(fsp_pkg::WIN_BITS));
    base      = start_bit_i[8:3];
    row_base  = {1'b0, base[5:2]};

    for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
      row_sig[k]   = row_base + ((2'(k) < base[1:0]) ? 5'd1 : 5'd0);
      byte_addr[k] = {row_sig[k], 2'(k)};
      if (is_raw) begin
        row_wide[k]        = fsp_pkg::ROW_CALC_W'(byte_index_i[5:2]);
        req_o.lane_en[k]   = idx_ok && (byte_index_i[1:0] == 2'(k));
      end else begin
        row_wide[k]        = fsp_pkg::ROW_CALC_W'(row_sig[k]);
        req_o.lane_en[k]   = 32'(byte_addr[k]) < 32'(BUF_BYTES);
      end
      row_o[k] = row_wide[k][ROW_W-1:0];
    end

    req_o.cmd      = cmd;
    req_o.err      = is_raw ? !idx_ok : !sig_ok;
    req_o.base_lo  = base[1:0];
    req_o.bit_off  = start_bit_i[2:0];
    req_o.bit_len  = bit_length_i;
    req_o.moto     = motorola_order_i;
    req_o.sgn      = signed_signal_i;
    req_o.byte_val = byte_value_i;
    req_o.sig_val  = signal_value_i;
  end

endmodule
`default_nettype wire

>>> hdl/fsp_merge.sv
// window assembly, signal insert merge, signal extract and result select
`default_nettype none
module fsp_merge (
  input  fsp_pkg::req_t  req_i,
  input  wire  [7:0]     lane_i [fsp_pkg::NUM_LANES],
  output logic           wr_en_o [fsp_pkg::NUM_LANES],
  output logic [7:0]     wr_data_o [fsp_pkg::NUM_LANES],
  output logic [31:0]    read_value_o,
  output logic           param_error_o
);

  logic [7:0]  lane [fsp_pkg::NUM_LANES];
  logic [31:0] win;
  logic [31:0] fmask;
  logic [5:0]  mask_sh;
  logic [5:0]  msh;
  logic [4:0]  sign_pos;
  logic [31:0] ins_v;
  logic [31:0] ins_m;
  logic [31:0] blk;
  logic [31:0] ext_w;
  logic [7:0]  raw_byte;
  logic [1:0]  sel;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  always_comb begin
    raw_byte = 8'd0;
    for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
      lane[k]  = req_i.lane_en[k] ? lane_i[k] : 8'd0;
      raw_byte = raw_byte | lane[k];
    end
    win = 32'd0;
    for (int j = 0; j < fsp_pkg::NUM_LANES; j++) begin
      sel = req_i.base_lo + 2'(j);
      win[8*j +: 8] = lane[sel];
    end

    mask_sh  = 6'(fsp_pkg::WIN_BITS) - req_i.bit_len;
    fmask    = 32'hFFFF_FFFF >> mask_sh;
    msh      = 6'(fsp_pkg::WIN_BITS) - 6'(req_i.bit_off) - req_i.bit_len;
    sign_pos = 5'(req_i.bit_len - 6'd1);

    // insert
    if (req_i.moto) begin
      ins_v = swap32((req_i.sig_val & fmask) << msh);
      ins_m = swap32(fmask << msh);
    end else begin
      ins_v = (req_i.sig_val & fmask) << req_i.bit_off;
      ins_m = fmask << req_i.bit_off;
    end
    blk = (win & ~ins_m) | (ins_v & ins_m);

    // extract
    if (req_i.moto) begin
      ext_w = swap32(win) >> msh;
    end else begin
      ext_w = win >> req_i.bit_off;
    end
    ext_w = ext_w & fmask;
    if (req_i.sgn && (req_i.bit_len < 6'(fsp_pkg::WIN_BITS)) && ext_w[sign_pos]) begin
      ext_w = ext_w | ~fmask;
    end

    for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
      sel = 2'(k) - req_i.base_lo;
      case (req_i.cmd)
        fsp_pkg::CMD_WRITE_BYTE: begin
          wr_en_o[k]   = req_i.lane_en[k];
          wr_data_o[k] = req_i.byte_val;
        end
        fsp_pkg::CMD_INSERT: begin
          wr_en_o[k]   = req_i.lane_en[k] && !req_i.err;
          wr_data_o[k] = blk[8*sel +: 8];
        end
        default: begin
          wr_en_o[k]   = 1'b0;
          wr_data_o[k] = blk[8*sel +: 8];
        end
      endcase
    end

    case (req_i.cmd)
      fsp_pkg::CMD_READ_BYTE: read_value_o = req_i.err ? 32'd0 : 32'(raw_byte);
      fsp_pkg::CMD_EXTRACT:   read_value_o = req_i.err ? 32'd0 : ext_w;
      default:                read_value_o = 32'd0;
    endcase
    param_error_o = req_i.err;
  end

endmodule
`default_nettype wire

>>> hdl/frame_signal_pack_unpack.sv
// top level of the frame signal pack/unpack block
// Takes one request per cycle unless the clearing pass or a stalled output holds it off, and
// returns one result per request, in order; a result passes through the merge stage register
// and then the output register. The frame buffer lives in four byte-wide banks (byte address
// modulo four), so the four-byte window of any signal touches each bank once; a request reads
// its window in the acceptance cycle, and the merge stage writes it back as the request leaves
// that stage, with a bypass between back-to-back requests. After reset a clearing pass zeroes
// one row of all four banks per cycle until every row is clear, during which no request is
// accepted.
`default_nettype none
module frame_signal_pack_unpack #(
  parameter int BUFFER_BITS     = 512,
  parameter int MAX_SIGNAL_BITS = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [1:0]   command_i,
  input  wire  [5:0]   byte_index_i,
  input  wire  [7:0]   byte_value_i,
  input  wire  [8:0]   start_bit_i,
  input  wire  [5:0]   bit_length_i,
  input  wire          motorola_order_i,
  input  wire          signed_signal_i,
  input  wire  [31:0]  signal_value_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [31:0]  read_value_o,
  output logic         param_error_o
);

  localparam int BUF_BYTES = BUFFER_BITS / 8;
  localparam int ROWS      = (BUF_BYTES + fsp_pkg::NUM_LANES - 1) / fsp_pkg::NUM_LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  fsp_pkg::req_t     dec_req;
  logic [ROW_W-1:0]  dec_row [fsp_pkg::NUM_LANES];

  fsp_pkg::req_t     s1_req_q;
  logic [ROW_W-1:0]  s1_row_q [fsp_pkg::NUM_LANES];
  logic              s1_valid_q;
  logic              byp_q [fsp_pkg::NUM_LANES];
  logic [7:0]        byp_data_q [fsp_pkg::NUM_LANES];

  logic [7:0]        ram_rdata [fsp_pkg::NUM_LANES];
  logic [7:0]        lane_data [fsp_pkg::NUM_LANES];
  logic              mrg_we [fsp_pkg::NUM_LANES];
  logic [7:0]        mrg_wdata [fsp_pkg::NUM_LANES];
  logic [31:0]       mrg_value;
  logic              mrg_err;

  logic              clr_busy_q;
  logic [ROW_W-1:0]  clr_row_q;

  logic              out_valid_q;
  logic [31:0]       read_value_q;
  logic              param_error_q;

  logic              s1_adv;
  logic              in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  fsp_decode #(
    .BUFFER_BITS     (BUFFER_BITS),
    .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS),
    .ROW_W           (ROW_W)
  ) u_decode (
    .command_i        (command_i),
    .byte_index_i     (byte_index_i),
    .byte_value_i     (byte_value_i),
    .start_bit_i      (start_bit_i),
    .bit_length_i     (bit_length_i),
    .motorola_order_i (motorola_order_i),
    .signed_signal_i  (signed_signal_i),
    .signal_value_i   (signal_value_i),
    .req_o            (dec_req),
    .row_o            (dec_row)
  );

  for (genvar k = 0; k < fsp_pkg::NUM_LANES; k++) begin : g_bank
    logic             bank_we;
    logic [ROW_W-1:0] bank_waddr;
    logic [7:0]       bank_wdata;

    assign bank_we    = clr_busy_q || (s1_adv && mrg_we[k]);
    assign bank_waddr = clr_busy_q ? clr_row_q : s1_row_q[k];
    assign bank_wdata = clr_busy_q ? 8'd0 : mrg_wdata[k];
    assign lane_data[k] = byp_q[k] ? byp_data_q[k] : ram_rdata[k];

    fsp_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .re_i    (in_acc && dec_req.lane_en[k]),
      .raddr_i (dec_row[k]),
      .rdata_o (ram_rdata[k])
    );
  end

  fsp_merge u_merge (
    .req_i         (s1_req_q),
    .lane_i        (lane_data),
    .wr_en_o       (mrg_we),
    .wr_data_o     (mrg_wdata),
    .read_value_o  (mrg_value),
    .param_error_o (mrg_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
        byp_q[k] <= 1'b0;
      end
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
          byp_q[k] <= s1_adv && mrg_we[k] && (s1_row_q[k] == dec_row[k]);
        end
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= dec_req;
      for (int k = 0; k < fsp_pkg::NUM_LANES; k++) begin
        s1_row_q[k]   <= dec_row[k];
        byp_data_q[k] <= mrg_wdata[k];
      end
    end
    if (s1_adv) begin
      read_value_q  <= mrg_value;
      param_error_q <= mrg_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign param_error_o = param_error_q;

  // no request in flight while the clearing pass runs
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_valid_q && !out_valid_q))
    else $error("request in flight during clearing pass");

  // a failed request never returns data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && param_error_q) |-> (read_value_q == 32'd0))
    else $error("failed request returned nonzero value");

  // accepting into a full merge stage only when it drains the same cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_valid_q) |-> s1_adv)
    else $error("merge stage overwritten");

  // a stalled result is not replaced
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(read_value_q)
      && $stable(param_error_q)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
